@@ hdl/quaternion_normalize_macros.svh @@
// Assertion macros for the quaternion normalize checker.
`ifndef QUATERNION_NORMALIZE_MACROS_SVH
`define QUATERNION_NORMALIZE_MACROS_SVH

// same-cycle implication, disabled in reset
`define QN_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define QN_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ hdl/qnorm_pkg.sv @@
// Package: widths and pipeline stage types for quaternion normalize.
package qnorm_pkg;
    localparam int CW    = 16;            // component width
    localparam int OW    = 16;            // output width
    localparam int OFRAC = 14;            // output fraction bits
    localparam int RW    = OFRAC + 1;     // result magnitude width
    localparam int SQW   = 2 * CW;        // one square
    localparam int SW    = 2 * CW + 2;    // sum of four squares
    localparam int TW    = 2 * CW + 2 * OFRAC + 2;
    localparam int PW    = SW + 2 * RW + 4;
    localparam int NSTEP = RW;
    localparam logic [RW-1:0] ONE_MAG = RW'(1) << OFRAC;

    typedef struct packed {
        logic                     valid;
        logic [3:0]               neg;
        logic [3:0][CW-1:0]       mag;
        logic [3:0][SQW-1:0]      sq;
        logic [SQW-1:0]           thr;
    } t_sq_stage;

    typedef struct packed {
        logic                     valid;
        logic                     degen;
        logic [3:0]               neg;
        logic [SW-1:0]            s;
        logic [3:0][TW-1:0]       t;
        logic [3:0][RW-1:0]       r;
        logic [3:0][PW-1:0]       p;
        logic [3:0][PW-1:0]       q;
    } t_step_stage;
endpackage

@@ hdl/quaternion_normalize.sv @@
// Top level: pipelined quaternion normalization with degenerate detection.
// Usage:
//   Input channel i_valid / o_stall carries i_qx..i_qw (signed, 12 fraction
//   bits); a request is taken on a clock edge with i_valid high and o_stall
//   low. Output channel o_valid / i_stall carries o_nx..o_nw (signed, 14
//   fraction bits) and o_degenerate; a result is taken when o_valid is high
//   and i_stall low.
//   i_cfg_we / i_cfg_data write the min_length threshold; write it only while
//   the pipeline is empty. Reset value is 1.
//   The pipeline takes one request per cycle while o_stall is low.
//   The result search has 15 digit stages, one result bit per stage for
//   all four lanes, between the summing and output stages; the squares
//   are registered by the edge that takes the request.
//   When i_stall holds a waiting result, the whole pipeline freezes and
//   o_stall rises; nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) empties the pipeline and restores the
//   threshold.
module quaternion_normalize
    import qnorm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_qx,
    input  logic signed [CW-1:0] i_qy,
    input  logic signed [CW-1:0] i_qz,
    input  logic signed [CW-1:0] i_qw,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [OW-1:0] o_nx,
    output logic signed [OW-1:0] o_ny,
    output logic signed [OW-1:0] o_nz,
    output logic signed [OW-1:0] o_nw,
    output logic                 o_degenerate,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data
);
    logic [15:0]        r_min_len;
    t_sq_stage          r_a, n_a;
    t_step_stage        r_pipe [0:NSTEP];
    t_step_stage        n_pipe [0:NSTEP];
    logic               r_ovalid;
    logic               r_odeg;
    logic [3:0][OW-1:0] r_onum, n_onum;
    logic               en;
    logic [3:0][CW-1:0] qin;

    assign en      = !(r_ovalid && i_stall);
    assign o_stall = !en;
    assign qin     = {i_qw, i_qz, i_qy, i_qx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= 16'd1;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_data;
        end
    end

    // squares and threshold square
    always_comb begin
        n_a.valid = i_valid;
        for (int i = 0; i < 4; i++) begin
            n_a.neg[i] = qin[i][CW-1];
            n_a.mag[i] = qin[i][CW-1] ? CW'(-qin[i]) : qin[i];
            n_a.sq[i]  = SQW'(n_a.mag[i]) * SQW'(n_a.mag[i]);
        end
        n_a.thr = SQW'(r_min_len) * SQW'(r_min_len);
    end

    // sum, degenerate test, search seed
    always_comb begin
        n_pipe[0].valid = r_a.valid;
        n_pipe[0].neg   = r_a.neg;
        n_pipe[0].s     = SW'(r_a.sq[0]) + SW'(r_a.sq[1]) + SW'(r_a.sq[2]) + SW'(r_a.sq[3]);
        n_pipe[0].degen = (n_pipe[0].s == '0) || (n_pipe[0].s < SW'(r_a.thr));
        for (int i = 0; i < 4; i++) begin
            n_pipe[0].t[i] = TW'(r_a.sq[i]) << (2 * OFRAC + 2);
            n_pipe[0].r[i] = '0;
            n_pipe[0].p[i] = PW'(n_pipe[0].s);
            n_pipe[0].q[i] = -PW'(n_pipe[0].s);
        end
    end

    // one result bit per stage: P = (2r-1)^2 S, Q = (2r-1) S
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        localparam int B = NSTEP - 1 - k;
        always_comb begin
            logic [PW-1:0] cand;
            n_pipe[k+1] = r_pipe[k];
            for (int i = 0; i < 4; i++) begin
                cand = r_pipe[k].p[i] + (r_pipe[k].q[i] << (B + 2))
                     + (PW'(r_pipe[k].s) << (2 * B + 2));
                if (!r_pipe[k].r[i][RW-1] && (cand <= PW'(r_pipe[k].t[i]))) begin
                    n_pipe[k+1].r[i] = r_pipe[k].r[i] | (RW'(1) << B);
                    n_pipe[k+1].p[i] = cand;
                    n_pipe[k+1].q[i] = r_pipe[k].q[i] + (PW'(r_pipe[k].s) << (B + 1));
                end
            end
        end
    end

    // sign and identity select
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_pipe[NSTEP].degen) begin
                n_onum[i] = (i == 3) ? OW'(ONE_MAG) : '0;
            end else if (r_pipe[NSTEP].neg[i]) begin
                n_onum[i] = -OW'(r_pipe[NSTEP].r[i]);
            end else begin
                n_onum[i] = OW'(r_pipe[NSTEP].r[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int j = 0; j <= NSTEP; j++) r_pipe[j].valid <= 1'b0;
        end else if (en) begin
            r_a      <= n_a;
            r_ovalid <= r_pipe[NSTEP].valid;
            r_odeg   <= r_pipe[NSTEP].degen;
            r_onum   <= n_onum;
            r_pipe[0] <= n_pipe[0];
            for (int j = 1; j <= NSTEP; j++) r_pipe[j] <= n_pipe[j];
        end
    end

    assign o_valid      = r_ovalid;
    assign o_degenerate = r_odeg;
    assign o_nx         = r_onum[0];
    assign o_ny         = r_onum[1];
    assign o_nz         = r_onum[2];
    assign o_nw         = r_onum[3];
endmodule

@@ hdl/qnorm_checker.sv @@
// Port-level checker for quaternion normalize, bound to the top level.
`include "quaternion_normalize_macros.svh"
module qnorm_checker
    import qnorm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic signed [OW-1:0] o_nx,
    input logic signed [OW-1:0] o_ny,
    input logic signed [OW-1:0] o_nz,
    input logic signed [OW-1:0] o_nw,
    input logic                 o_degenerate
);
    `QN_ASSERT_IMP(a_identity, i_clk, i_rst_n, o_valid && o_degenerate, o_nx == 0 && o_ny == 0 && o_nz == 0 && o_nw == 16384)
    `QN_ASSERT_IMP(a_range, i_clk, i_rst_n, o_valid, o_nx <= 16384 && o_nx >= -16384 && o_nw <= 16384 && o_nw >= -16384)
    `QN_ASSERT_IMP(a_backpressure, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `QN_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_nx) && $stable(o_degenerate))
endmodule

bind quaternion_normalize qnorm_checker u_qnorm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall), .o_valid(o_valid),
    .i_stall(i_stall), .o_nx(o_nx), .o_ny(o_ny), .o_nz(o_nz), .o_nw(o_nw),
    .o_degenerate(o_degenerate)
);

@@ tb/quaternion_normalize_tb.sv @@
// Testbench for quaternion_normalize: queued driver, predicting monitor, threshold phases.
module quaternion_normalize_tb;
    import qnorm_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0] x, y, z, w;
    } t_quat;

    typedef struct packed {
        logic signed [OW-1:0] nx, ny, nz, nw;
        logic                 degen;
    } t_unit_quat;

    logic                 i_clk, i_rst_n;
    logic                 i_valid, o_stall, o_valid, i_stall;
    logic signed [CW-1:0] i_qx, i_qy, i_qz, i_qw;
    logic signed [OW-1:0] o_nx, o_ny, o_nz, o_nw;
    logic                 o_degenerate;
    logic                 i_cfg_we;
    logic [15:0]          i_cfg_data;

    t_quat       pending_quats[$];
    t_unit_quat  expected_units[$];
    logic [15:0] min_length;
    logic        req_taken;
    logic        calm;
    int          send_gap, stall_left, errors;

    quaternion_normalize DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_qx(i_qx), .i_qy(i_qy), .i_qz(i_qz), .i_qw(i_qw),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_nx(o_nx), .o_ny(o_ny), .o_nz(o_nz), .o_nw(o_nw),
        .o_degenerate(o_degenerate), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [OW-1:0] scale_lane(logic signed [CW-1:0] c, logic [33:0] s);
        logic [16:0]  mag;
        logic [127:0] rhs, lhs, odd;
        logic [15:0]  r, cand;
        mag = c[CW-1] ? 17'(-$signed({c[CW-1], c})) : 17'(c);
        rhs = (128'(mag) * 128'(mag)) << 30;
        r = 16'd0;
        for (int b = OFRAC; b >= 0; b--) begin
            cand = r | (16'd1 << b);
            if (cand <= 16'd16384) begin
                odd = 128'(2 * cand - 1);
                lhs = odd * odd * 128'(s);
                if (lhs <= rhs) r = cand;
            end
        end
        return c[CW-1] ? OW'(-r) : OW'(r);
    endfunction

    function automatic t_unit_quat normalize(t_quat q, logic [15:0] thr);
        t_unit_quat  u;
        logic [33:0] s;
        logic [16:0] m[4];
        logic signed [CW-1:0] c[4];
        c[0] = q.x; c[1] = q.y; c[2] = q.z; c[3] = q.w;
        s = '0;
        for (int i = 0; i < 4; i++) begin
            m[i] = c[i][CW-1] ? 17'(-$signed({c[i][CW-1], c[i]})) : 17'(c[i]);
            s = s + 34'(m[i]) * 34'(m[i]);
        end
        if (s == 0 || s < 34'(thr) * 34'(thr)) begin
            u = '{nx: '0, ny: '0, nz: '0, nw: OW'(16384), degen: 1'b1};
        end else begin
            u.nx = scale_lane(q.x, s);
            u.ny = scale_lane(q.y, s);
            u.nz = scale_lane(q.z, s);
            u.nw = scale_lane(q.w, s);
            u.degen = 1'b0;
        end
        return u;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (calm || p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_quat q;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !req_taken)) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_quats.size() > 0) begin
                q = pending_quats.pop_front();
                i_qx <= q.x; i_qy <= q.y; i_qz <= q.z; i_qw <= q.w;
                i_valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            stall_left = pick_gap();
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left = stall_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_unit_quat e;
        req_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_units.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                e = expected_units.pop_front();
                if (o_nx !== e.nx) begin
                    $error("nx expected %0d actual %0d", e.nx, o_nx); errors++;
                end
                if (o_ny !== e.ny) begin
                    $error("ny expected %0d actual %0d", e.ny, o_ny); errors++;
                end
                if (o_nz !== e.nz) begin
                    $error("nz expected %0d actual %0d", e.nz, o_nz); errors++;
                end
                if (o_nw !== e.nw) begin
                    $error("nw expected %0d actual %0d", e.nw, o_nw); errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate expected %0d actual %0d", e.degen, o_degenerate);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall)
            expected_units.push_back(normalize('{x: i_qx, y: i_qy, z: i_qz, w: i_qw},
                                               min_length));
    end

    function automatic logic [15:0] rand_comp();
        int p;
        p = $urandom_range(9);
        if (p < 4) return 16'($urandom);
        if (p < 7) return 16'($signed($urandom_range(64)) - 32);
        if (p < 8) return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
        return 16'd0;
    endfunction

    // settle past the driver's updates at each falling edge before checking
    task automatic drain();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_quats.size() != 0 || i_valid || expected_units.size() != 0);
        repeat (25) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        min_length = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int n);
        t_quat q;
        for (int i = 0; i < n; i++) begin
            q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp(); q.w = rand_comp();
            pending_quats.push_back(q);
        end
    endtask

    initial begin
        errors = 0; send_gap = 0; stall_left = 0; calm = 1'b0;
        min_length = 16'd1;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; req_taken = 1'b0;
        i_qx = '0; i_qy = '0; i_qz = '0; i_qw = '0;
        i_cfg_we = 1'b0; i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero, extremes, single LSB, most negative, mixed signs
        pending_quats.push_back('{x: 0, y: 0, z: 0, w: 0});
        pending_quats.push_back('{x: 1, y: 0, z: 0, w: 0});
        pending_quats.push_back('{x: 0, y: 0, z: 0, w: -1});
        pending_quats.push_back('{x: -32768, y: 0, z: 0, w: 0});
        pending_quats.push_back('{x: -32768, y: -32768, z: -32768, w: -32768});
        pending_quats.push_back('{x: 32767, y: 32767, z: 32767, w: 32767});
        pending_quats.push_back('{x: 32767, y: -32768, z: 32767, w: -32768});
        pending_quats.push_back('{x: 0, y: 0, z: 0, w: 4096});
        pending_quats.push_back('{x: 3, y: 4, z: 0, w: 0});
        pending_quats.push_back('{x: 1, y: 1, z: 1, w: 1});
        pending_quats.push_back('{x: -1, y: 2, z: -2, w: 0});
        pending_quats.push_back('{x: 16'h5555, y: 16'hAAAA, z: 16'h00FF, w: 16'hFF00});
        drain();
        write_threshold(16'd0);
        pending_quats.push_back('{x: 0, y: 0, z: 0, w: 0});
        pending_quats.push_back('{x: 0, y: 1, z: 0, w: 0});
        drain();
        write_threshold(16'd3);
        pending_quats.push_back('{x: 2, y: 2, z: 0, w: 0});
        pending_quats.push_back('{x: 2, y: 2, z: 1, w: 0});
        pending_quats.push_back('{x: 3, y: 0, z: 0, w: 0});
        drain();
        write_threshold(16'hFFFF);
        pending_quats.push_back('{x: -32768, y: -32768, z: -32768, w: -32768});
        pending_quats.push_back('{x: 32767, y: 32767, z: 32767, w: 32767});
        drain();

        // random phases, each ending with a full drain
        write_threshold(16'd1);     queue_random(150); drain();
        write_threshold(16'd0);     calm = 1'b1; queue_random(100); drain(); calm = 1'b0;
        write_threshold(16'd40);    queue_random(130); drain();
        write_threshold(16'hFFFF);  queue_random(80);  drain();
        write_threshold(16'h8000);  queue_random(80);  drain();
        write_threshold(16'($urandom)); queue_random(100); drain();
        write_threshold(16'd1);     queue_random(110); drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(20 * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ quaternion_normalize.f @@
+incdir+hdl
hdl/qnorm_pkg.sv
hdl/quaternion_normalize.sv
hdl/qnorm_checker.sv
tb/quaternion_normalize_tb.sv
